/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge while reset is released.
`define FPR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property violated");

// Checks that a condition never holds while reset is released.
`define FPR_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/fpr_pkg.sv */
package fpr_pkg;

  // Default packet length in bytes, header and trailer included.
  localparam int PacketBytesDef = 8;

  // Framing bytes.
  localparam logic [7:0] HeaderByte  = 8'hAA;
  localparam logic [7:0] TrailerByte = 8'h55;

  // Depth of the packet queue between front and back.
  localparam int QDepth = 2;

  // Configuration space.
  localparam int          PaddrW          = 3;
  localparam logic [PaddrW-1:0] StationAddrOffset = 3'd0;
  localparam logic [7:0]  StationAddrReset = 8'd2;

  // Request source codes.
  localparam logic ReqLink = 1'b0;
  localparam logic ReqBus  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       ninth_bit;
  } fpr_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } fpr_out_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic valid;
  } fpr_qstat_t;

endpackage

/* rtl/fpr_fifo.sv */
module fpr_fifo #(
  parameter int Width = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [Width-1:0]    push_data_i,
  input  logic                pop_i,
  output logic [Width-1:0]    pop_data_o,
  output fpr_pkg::fpr_qstat_t stat_o
);
  import fpr_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  logic [Width-1:0] entry_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  // Pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(QDepth));
  assign stat_o.valid = (count_q != '0);

endmodule

/* rtl/fpr_front.sv */
module fpr_front #(
  parameter int PacketBytes = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  station_addr_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fpr_pkg::fpr_in_t            in_data_i,
  input  fpr_pkg::fpr_qstat_t         qstat_i,
  output logic                        push_o,
  output logic [PacketBytes-1:0][7:0] push_data_o
);
  import fpr_pkg::*;

  localparam int PosW = $clog2(PacketBytes);
  localparam logic [PosW-1:0] LastPos = PosW'(PacketBytes - 1);

  logic [PosW-1:0]             pos_q, pos_d;
  logic                        fresh_q, fresh_d;
  logic [PacketBytes-1:0][7:0] work_q;
  logic [PacketBytes-1:0][7:0] latched_q;
  logic [PacketBytes-1:0][7:0] latch_val;
  logic                        accept;
  logic                        link_req;
  logic                        is_header;
  logic                        in_body;
  logic                        at_trailer;
  logic                        work_we;
  logic                        latch_we;
  logic                        poll_hit;

  // The queue being full holds off every request.
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;

  // Classify the request.
  assign link_req   = accept && (in_data_i.req_type == ReqLink);
  assign is_header  = (in_data_i.data_byte == HeaderByte);
  assign in_body    = (pos_q != '0) && (pos_q < LastPos);
  assign at_trailer = (pos_q == LastPos);
  assign work_we    = link_req && !is_header && in_body;
  assign latch_we   = link_req && !is_header && at_trailer &&
                      (in_data_i.data_byte == TrailerByte);
  assign poll_hit   = accept && (in_data_i.req_type == ReqBus) && in_data_i.ninth_bit &&
                      (in_data_i.data_byte == station_addr_i) && fresh_q;

  // Deframing position and fresh mark.
  always_comb begin
    pos_d   = pos_q;
    fresh_d = fresh_q;
    if (link_req) begin
      if (is_header) begin
        pos_d = PosW'(1);
      end else if (in_body) begin
        pos_d = pos_q + 1'b1;
      end else begin
        pos_d = '0;
      end
    end
    if (latch_we) begin
      fresh_d = 1'b1;
    end else if (poll_hit) begin
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fresh_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      fresh_q <= fresh_d;
    end
  end

  // The completed packet is the working buffer closed by the trailer.
  always_comb begin
    latch_val              = work_q;
    latch_val[PacketBytes-1] = TrailerByte;
  end

  // Packet buffers carry no reset.
  always_ff @(posedge clk_i) begin
    if (link_req && is_header) begin
      work_q[0] <= HeaderByte;
    end else if (work_we) begin
      work_q[pos_q] <= in_data_i.data_byte;
    end
    if (latch_we) begin
      latched_q <= latch_val;
    end
  end

  // A poll snapshots the latched packet into the queue.
  assign push_o      = poll_hit;
  assign push_data_o = latched_q;

endmodule

/* rtl/fpr_back.sv */
module fpr_back #(
  parameter int PacketBytes = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fpr_pkg::fpr_qstat_t         qstat_i,
  input  logic [PacketBytes-1:0][7:0] pop_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fpr_pkg::fpr_out_t           out_data_o
);
  import fpr_pkg::*;

  localparam int IdxW = $clog2(PacketBytes);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PacketBytes - 1);

  typedef enum logic [1:0] {
    BkIdle = 2'b01,
    BkSend = 2'b10
  } bk_state_e;

  bk_state_e                   state_q, state_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  fpr_out_t                    out_q;
  logic [PacketBytes-1:0][7:0] pkt_q;
  logic                        adv;
  logic                        emit;

  // The output register may be refilled when empty or when taken.
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = (state_q == BkIdle) && qstat_i.valid;
  assign emit  = (state_q == BkSend) && adv;

  // Sequencer: load a packet, then emit one byte per free output slot.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      BkIdle: begin
        if (adv) begin
          out_valid_d = 1'b0;
        end
        if (qstat_i.valid) begin
          state_d = BkSend;
          idx_d   = '0;
        end
      end
      BkSend: begin
        if (adv) begin
          out_valid_d = 1'b1;
          idx_d       = idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            state_d = BkIdle;
          end
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Packet shift register and output payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pkt_q <= pop_data_i;
    end else if (emit) begin
      pkt_q <= {8'h00, pkt_q[PacketBytes-1:1]};
    end
    if (emit) begin
      out_q.tx_byte   <= pkt_q[0];
      out_q.last_byte <= (idx_q == LastIdx);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/framed_packet_relay_with_address_poll_core.sv */
// Link bytes and non-matching bus bytes give no result. A matching poll passes through
// the queue, then the back's packet register, then the output register before its first
// byte shows; the back emits PacketBytes results at one per cycle while the output is not
// stalled. Input stalls only while the two-entry queue is full.
// Reset is asynchronous: framing position, fresh mark, queue and output clear,
// and the station address returns to 2; packet buffers need no clearing pass.
`include "assert_macros.svh"

module framed_packet_relay_with_address_poll_core #(
  parameter int PacketBytes = fpr_pkg::PacketBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  fpr_pkg::fpr_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output fpr_pkg::fpr_out_t          out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpr_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import fpr_pkg::*;

  logic [7:0]                  station_q;
  logic                        cfg_we;
  logic                        q_push;
  logic                        q_pop;
  logic [PacketBytes-1:0][7:0] q_wdata;
  logic [PacketBytes-1:0][7:0] q_rdata;
  logic [PacketBytes*8-1:0]    q_rflat;
  fpr_qstat_t                  q_stat;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == StationAddrOffset);
  assign prdata = (paddr == StationAddrOffset) ? {24'h000000, station_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= StationAddrReset;
    end else if (cfg_we) begin
      station_q <= pwdata[7:0];
    end
  end

  // Front: deframing and poll matching.
  fpr_front #(
    .PacketBytes(PacketBytes)
  ) u_front (
    .clk_i,
    .rst_ni,
    .station_addr_i(station_q),
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .qstat_i       (q_stat),
    .push_o        (q_push),
    .push_data_o   (q_wdata)
  );

  // Queue of polled packets.
  fpr_fifo #(
    .Width(PacketBytes * 8)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .pop_i      (q_pop),
    .pop_data_o (q_rflat),
    .stat_o     (q_stat)
  );

  assign q_rdata = q_rflat;

  // Back: byte sequencer and output register.
  fpr_back #(
    .PacketBytes(PacketBytes)
  ) u_back (
    .clk_i,
    .rst_ni,
    .qstat_i    (q_stat),
    .pop_data_i (q_rdata),
    .pop_o      (q_pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  // A poll never lands in a full queue nor a pop in an empty one; configuration writes take effect.
  `FPR_NEVER(a_push_when_full, clk_i, rst_ni, q_push && q_stat.full)
  `FPR_NEVER(a_pop_when_empty, clk_i, rst_ni, q_pop && !q_stat.valid)
  `FPR_ASSERT(a_cfg_write, clk_i, rst_ni, cfg_we |=> (station_q == $past(pwdata[7:0])))

endmodule
